### rtl/core/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window max block
// Sample and count widths, the window length reset value and the
// selector result struct.
// ---------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int LEN_BITS    = 7;
    localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int IDX_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(8);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [LEN_BITS-1:0]           t_len;
    typedef logic [CNT_BITS-1:0]           t_cnt;

    // window selector result for the current request
    typedef struct packed {
        logic    emit;
        t_sample window_max;
    } t_sel_res;

endpackage

`default_nettype wire

### rtl/core/swm_cell.sv
// ---------------------------------------------------------------------------
// swm_cell: one stage of the running max chain
// Cell k holds the largest of the last k+1 samples; on each request it
// takes the max of the new sample and its lower neighbor's value.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_cell (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire swm_pkg::t_sample i_sample,
    input  wire swm_pkg::t_sample i_nbr_max,
    output swm_pkg::t_sample     o_max
);
    import swm_pkg::*;

    t_sample r_max;
    t_sample n_max;

    always_comb begin
        n_max = (i_nbr_max > i_sample) ? i_nbr_max : i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_max <= n_max;
        end
    end

    assign o_max = r_max;

endmodule

`default_nettype wire

### rtl/core/swm_win_sel.sv
// ---------------------------------------------------------------------------
// swm_win_sel: window result selector
// Clamps the window length, decides whether a result is due and merges
// the new sample with the cell max that spans the rest of the window.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_win_sel (
    input  wire swm_pkg::t_len    i_window_len,
    input  wire swm_pkg::t_cnt    i_fill_next,
    input  wire swm_pkg::t_sample i_sample,
    input  wire swm_pkg::t_sample i_cell_max [swm_pkg::MAX_WINDOW],
    output swm_pkg::t_sel_res     o_res
);
    import swm_pkg::*;

    t_cnt                eff_len;
    logic [IDX_BITS-1:0] tap;
    t_sample             older_max;

    always_comb begin
        // zero means one sample, anything past the store is the full store
        if (i_window_len == '0) begin
            eff_len = CNT_BITS'(1);
        end else if (CNT_BITS'(i_window_len) > CNT_BITS'(MAX_WINDOW)) begin
            eff_len = CNT_BITS'(MAX_WINDOW);
        end else begin
            eff_len = CNT_BITS'(i_window_len);
        end

        // cell (len-2) covers the len-1 samples before the new one
        tap       = IDX_BITS'(eff_len - CNT_BITS'(2));
        older_max = i_cell_max[tap];

        o_res.emit = (i_fill_next >= eff_len);
        if (eff_len == CNT_BITS'(1)) begin
            o_res.window_max = i_sample;
        end else begin
            o_res.window_max = (older_max > i_sample) ? older_max : i_sample;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sliding_window_max_top.sv
// ---------------------------------------------------------------------------
// sliding_window_max_top: running maximum over a sliding sample window
// Signed samples enter a row of max cells; once a sequence holds at least
// window_len samples, each sample yields the max of the last window_len.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_sample, i_start_new
//  out      | output    | o_out_valid / i_out_ready | o_window_max
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_window_len
//
//  One request per clock while o_in_ready is high. The result of a request
//  shows on the out channel the cycle after it is taken, set by the single
//  compare-and-select path from the cell row into the output register.
//  A request that completes no window gives no result.
//  i_rst_n (sync, active low) clears fill count, window length (to 8) and
//  the output valid; cell contents are left as they are.
//  o_in_ready drops only while a result waits in the output register and
//  the sink holds i_out_ready low. The cfg channel is always ready.
//
`default_nettype none

module sliding_window_max_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // sample requests
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire swm_pkg::t_sample i_sample,
    input  wire logic             i_start_new,
    // results
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output swm_pkg::t_sample      o_window_max,
    // window length register
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire swm_pkg::t_len    i_cfg_window_len
);
    import swm_pkg::*;

    t_len     r_window_len;
    t_cnt     r_fill;
    t_cnt     n_fill;
    logic     r_out_valid;
    t_sample  r_window_max;

    logic     in_acc;
    t_sel_res sel_res;
    t_sample  cell_max [MAX_WINDOW];

    // output register frees up when empty or being drained this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    // fill count: restarts on a new sequence, saturates at the store depth
    always_comb begin
        if (i_start_new) begin
            n_fill = CNT_BITS'(1);
        end else if (r_fill == CNT_BITS'(MAX_WINDOW)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + CNT_BITS'(1);
        end
    end

    // cell row: cell 0 sees the sample as its own neighbor, so it just
    // loads the sample; every other cell extends its neighbor by one
    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        if (k == 0) begin : g_head
            swm_cell u_cell (
                .i_clk     (i_clk),
                .i_en      (in_acc),
                .i_sample  (i_sample),
                .i_nbr_max (i_sample),
                .o_max     (cell_max[k])
            );
        end else begin : g_body
            swm_cell u_cell (
                .i_clk     (i_clk),
                .i_en      (in_acc),
                .i_sample  (i_sample),
                .i_nbr_max (cell_max[k-1]),
                .o_max     (cell_max[k])
            );
        end
    end

    // result for this request, read from the cells before they shift
    swm_win_sel u_win_sel (
        .i_window_len (r_window_len),
        .i_fill_next  (n_fill),
        .i_sample     (i_sample),
        .i_cell_max   (cell_max),
        .o_res        (sel_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= LEN_RESET;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window_len <= i_cfg_window_len;
            end
            if (in_acc) begin
                r_fill      <= n_fill;
                r_out_valid <= sel_res.emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc && sel_res.emit) begin
            r_window_max <= sel_res.window_max;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_window_max;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------

    // a new sequence always restarts filling at one sample
    a_start_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_start_new) |=> (r_fill == CNT_BITS'(1)))
        else $error("fill count did not restart on new sequence");

    // fill count never runs past the store depth
    a_fill_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= CNT_BITS'(MAX_WINDOW)))
        else $error("fill count past store depth");

    // a result is never below the sample that produced it
    a_max_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && sel_res.emit) |=> (o_out_valid && (o_window_max >= $past(i_sample))))
        else $error("window max below newest sample");

    // no result for the first sample of a sequence when the window is longer than one
    a_no_early : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_start_new && (r_window_len > LEN_BITS'(1))) |=> !o_out_valid)
        else $error("result given before window filled");

endmodule

`default_nettype wire
